// ===== rtl/player_status_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Player status frame receiver assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PLAYER_STATUS_FRAME_RECEIVER_DEFINES_SVH
`define PLAYER_STATUS_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("player status frame receiver: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("player status frame receiver: next-cycle check failed");

`endif

// ===== rtl/psfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Player status frame receiver package
// Beat types, command codes and frame constants shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psfr_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned PosW     = 4;
  localparam int unsigned SumW     = 11;

  localparam logic [PosW-1:0] POS_CMD      = PosW'(3);
  localparam logic [PosW-1:0] POS_ARG_HI   = PosW'(5);
  localparam logic [PosW-1:0] POS_ARG_LO   = PosW'(6);
  localparam logic [PosW-1:0] POS_CSUM_HI  = PosW'(7);
  localparam logic [PosW-1:0] POS_CSUM_LO  = PosW'(8);
  localparam logic [PosW-1:0] POS_SUM_LAST = PosW'(6);
  localparam logic [PosW-1:0] POS_LAST     = PosW'(FrameLen - 1);

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [7:0] CMD_DONE_A = 8'h3C;
  localparam logic [7:0] CMD_DONE_B = 8'h3D;
  localparam logic [7:0] CMD_DONE_C = 8'h3E;
  localparam logic [7:0] CMD_VOLUME = 8'h43;
  localparam logic [7:0] CMD_FILES  = 8'h48;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  command_code;
    logic [15:0] argument_word;
    logic [15:0] volume_level;
    logic [15:0] file_total;
    logic        play_completed;
    logic [31:0] good_frames;
  } out_beat_t;

endpackage

// ===== rtl/psfr_frame_core.sv =====
// ----------------------------------------------------------------------------
// Player status frame core
// Frame position, running checksum, held fields and status stores; gives the
// result of the presented beat combinationally and updates on accept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psfr_frame_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  psfr_pkg::in_beat_t  beat,
  output psfr_pkg::out_beat_t result
);
  import psfr_pkg::*;

  logic [PosW-1:0] position;
  logic [PosW-1:0] position_next;
  logic [SumW-1:0] running_sum;
  logic [SumW-1:0] running_sum_next;
  logic            sum_match;
  logic            sum_match_next;
  logic [7:0]      held_command;
  logic [7:0]      held_arg_hi;
  logic [7:0]      held_arg_lo;
  logic [7:0]      checksum_high;
  logic [15:0]     volume_store;
  logic [15:0]     volume_store_next;
  logic [15:0]     file_count_store;
  logic [15:0]     file_count_store_next;
  logic            completed_flag;
  logic            completed_flag_next;
  logic [31:0]     frame_counter;
  logic [31:0]     frame_counter_next;

  logic        is_rx;
  logic        in_sum;
  logic        last_byte;
  logic        good;
  logic [15:0] neg_sum;
  logic [15:0] held_argument;

  assign is_rx         = (beat.opcode == OP_RX_BYTE);
  assign in_sum        = (position != '0) && (position <= POS_SUM_LAST);
  assign last_byte     = is_rx && (position >= POS_LAST);
  assign good          = last_byte && sum_match;
  assign neg_sum       = 16'd0 - {5'd0, running_sum};
  assign held_argument = {held_arg_hi, held_arg_lo};

  always_comb begin
    position_next         = position;
    running_sum_next      = running_sum;
    sum_match_next        = sum_match;
    volume_store_next     = volume_store;
    file_count_store_next = file_count_store;
    completed_flag_next   = completed_flag;
    frame_counter_next    = frame_counter;
    if (!is_rx) begin
      completed_flag_next = 1'b0;
    end else if (last_byte) begin
      position_next    = '0;
      running_sum_next = '0;
      sum_match_next   = 1'b0;
      if (good) begin
        if (held_command == CMD_DONE_A || held_command == CMD_DONE_B ||
            held_command == CMD_DONE_C) begin
          completed_flag_next = 1'b1;
        end else if (held_command == CMD_VOLUME) begin
          volume_store_next = held_argument;
        end else if (held_command == CMD_FILES) begin
          file_count_store_next = held_argument;
        end
        frame_counter_next = frame_counter + 32'd1;
      end
    end else begin
      position_next = position + PosW'(1);
      if (in_sum) begin
        running_sum_next = running_sum + {3'd0, beat.rx_byte};
      end
      if (position == POS_CSUM_LO) begin
        sum_match_next = ({checksum_high, beat.rx_byte} == neg_sum);
      end
    end
  end

  always_comb begin
    result.frame_done     = last_byte;
    result.frame_ok       = good;
    result.command_code   = last_byte ? held_command : 8'd0;
    result.argument_word  = last_byte ? held_argument : 16'd0;
    result.volume_level   = volume_store_next;
    result.file_total     = file_count_store_next;
    result.play_completed = completed_flag_next;
    result.good_frames    = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      running_sum      <= '0;
      sum_match        <= 1'b0;
      volume_store     <= '0;
      file_count_store <= '0;
      completed_flag   <= 1'b0;
      frame_counter    <= '0;
    end else if (accept) begin
      position         <= position_next;
      running_sum      <= running_sum_next;
      sum_match        <= sum_match_next;
      volume_store     <= volume_store_next;
      file_count_store <= file_count_store_next;
      completed_flag   <= completed_flag_next;
      frame_counter    <= frame_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_rx) begin
      if (position == POS_CMD) begin
        held_command <= beat.rx_byte;
      end
      if (position == POS_ARG_HI) begin
        held_arg_hi <= beat.rx_byte;
      end
      if (position == POS_ARG_LO) begin
        held_arg_lo <= beat.rx_byte;
      end
      if (position == POS_CSUM_HI) begin
        checksum_high <= beat.rx_byte;
      end
    end
  end

endmodule

// ===== rtl/player_status_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Player status frame receiver
// Groups received player bytes into ten-byte frames, checks them and keeps
// the reported status.
// ----------------------------------------------------------------------------
// Each accepted beat on the byte channel is either a received byte or a
// request to clear the play-completed flag. Every accepted beat produces
// exactly one status beat on the status channel, in order.
// A status beat is registered in the output register, or parked in the skid
// register while the status channel stalls. One byte beat can be accepted every
// cycle while byte_stall is low.
// When the status channel stalls, one further result is parked in a skid
// register; byte_stall rises only while that skid register is full, and the
// parked result goes out first once the stall drops.
// Reset clears the frame position, checksum, status stores, frame counter
// and the valid flags of both output registers. Reset is synchronous; no sweep
// follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "player_status_frame_receiver_defines.svh"

module player_status_frame_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  psfr_pkg::in_beat_t  byte_beat,
  output logic                status_valid,
  input  logic                status_stall,
  output psfr_pkg::out_beat_t status_beat
);
  import psfr_pkg::*;

  logic      accept;
  logic      skid_valid;
  out_beat_t skid_beat;
  out_beat_t result;

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !skid_valid;

  psfr_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (byte_beat),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!status_valid || !status_stall) begin
      if (skid_valid) begin
        status_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        status_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!status_valid || !status_stall) begin
      if (skid_valid) begin
        status_beat <= skid_beat;
      end else if (accept) begin
        status_beat <= result;
      end
    end else if (accept) begin
      skid_beat <= result;
    end
  end

  `PSFR_ASSERT_NOW(a_skid_behind_output, skid_valid, status_valid)
  `PSFR_ASSERT_NOW(a_ok_needs_done, status_valid && status_beat.frame_ok,
                   status_beat.frame_done)
  `PSFR_ASSERT_NOW(a_clear_no_frame, accept && byte_beat.opcode == OP_CLEAR,
                   !result.frame_done && !result.play_completed)
  `PSFR_ASSERT_NEXT(a_skid_fill, status_valid && status_stall && accept,
                    skid_valid && status_valid)

endmodule

// ===== dv/player_status_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// Player status frame receiver testbench
// Streams framed and unframed player bytes and clear requests into the block
// with bursty input and a patterned output stall. Every byte beat is predicted
// on acceptance, and each status beat is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module player_status_frame_receiver_tb;
  import psfr_pkg::*;

  localparam int TargetBeats = 850;
  localparam int DrainPoint  = 400;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      byte_valid   = 1'b0;
  logic      byte_stall;
  in_beat_t  byte_beat    = '0;
  logic      status_valid;
  logic      status_stall = 1'b0;
  out_beat_t status_beat;

  in_beat_t  byte_items[$];
  out_beat_t status_due[$];
  int        frame_fill   = 0;
  int        total_beats  = 0;
  int        beats_sent   = 0;
  int        error_count  = 0;
  int        burst_left   = 0;
  int        gap_left     = 0;
  bit        drain_done   = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;
  int        stall_phase_left = 0;

  logic [PosW-1:0] pos_q      = '0;
  logic [SumW-1:0] sum_q      = '0;
  logic [7:0]      cmd_q      = '0;
  logic [15:0]     arg_q      = '0;
  logic [7:0]      csum_hi_q  = '0;
  logic            match_q    = 1'b0;
  logic [15:0]     volume_q   = '0;
  logic [15:0]     files_q    = '0;
  logic            finished_q = 1'b0;
  logic [31:0]     frames_q   = '0;

  player_status_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status_beat  (status_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_beat_t frame_status_next(in_beat_t b);
    out_beat_t   r;
    logic [15:0] neg;
    r = '0;
    if (b.opcode == OP_CLEAR) begin
      finished_q = 1'b0;
    end else begin
      if (pos_q >= PosW'(1) && pos_q <= POS_SUM_LAST) sum_q = sum_q + SumW'(b.rx_byte);
      if (pos_q == POS_CMD) cmd_q = b.rx_byte;
      if (pos_q == POS_ARG_HI) arg_q = {b.rx_byte, 8'h00};
      if (pos_q == POS_ARG_LO) arg_q[7:0] = b.rx_byte;
      if (pos_q == POS_CSUM_HI) csum_hi_q = b.rx_byte;
      if (pos_q == POS_CSUM_LO) begin
        neg     = 16'(17'h10000 - 17'(sum_q));
        match_q = ({csum_hi_q, b.rx_byte} == neg);
      end
      if (pos_q >= POS_LAST) begin
        r.frame_done    = 1'b1;
        r.frame_ok      = match_q;
        r.command_code  = cmd_q;
        r.argument_word = arg_q;
        if (match_q) begin
          if (cmd_q == CMD_DONE_A || cmd_q == CMD_DONE_B || cmd_q == CMD_DONE_C) begin
            finished_q = 1'b1;
          end else if (cmd_q == CMD_VOLUME) begin
            volume_q = arg_q;
          end else if (cmd_q == CMD_FILES) begin
            files_q = arg_q;
          end
          frames_q = frames_q + 32'd1;
        end
        pos_q   = '0;
        sum_q   = '0;
        match_q = 1'b0;
      end else begin
        pos_q = pos_q + PosW'(1);
      end
    end
    r.volume_level   = volume_q;
    r.file_total     = files_q;
    r.play_completed = finished_q;
    r.good_frames    = frames_q;
    return r;
  endfunction

  task automatic push_beat(logic op, logic [7:0] b);
    byte_items.push_back('{opcode: op, rx_byte: b});
    if (op == OP_RX_BYTE) frame_fill = (frame_fill + 1) % FrameLen;
  endtask

  // A fill below zero gives random filler bytes.
  task automatic add_frame(logic [7:0] cmd, logic [15:0] arg, int fill, bit bad, int clear_at);
    logic [7:0]  fb [FrameLen];
    logic [15:0] sum;
    logic [15:0] csum;
    while (frame_fill != 0) push_beat(OP_RX_BYTE, 8'($urandom));
    for (int i = 0; i < FrameLen; i++) fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    fb[POS_CMD]    = cmd;
    fb[POS_ARG_HI] = arg[15:8];
    fb[POS_ARG_LO] = arg[7:0];
    sum = '0;
    for (int i = 1; i <= int'(POS_SUM_LAST); i++) sum = sum + 16'(fb[i]);
    csum = -sum;
    if (bad) csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
    fb[POS_CSUM_HI] = csum[15:8];
    fb[POS_CSUM_LO] = csum[7:0];
    for (int i = 0; i < FrameLen; i++) begin
      if (i == clear_at) push_beat(OP_CLEAR, 8'($urandom));
      push_beat(OP_RX_BYTE, fb[i]);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    logic [7:0]  cmd;
    logic [15:0] arg;
    int          pick;
    int          clear_at;

    add_frame(CMD_DONE_A, 16'hFFFF, 8'hFF, 1'b0, 4);
    push_beat(OP_CLEAR, 8'hFF);
    add_frame(8'h00, 16'h0000, 8'h00, 1'b1, -1);
    push_beat(OP_CLEAR, 8'h00);

    while (byte_items.size() < TargetBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        case ($urandom_range(0, 6))
          0:       cmd = CMD_DONE_A;
          1:       cmd = CMD_DONE_B;
          2:       cmd = CMD_DONE_C;
          3:       cmd = CMD_VOLUME;
          4:       cmd = CMD_FILES;
          default: cmd = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       arg = 16'h0000;
          1:       arg = 16'hFFFF;
          default: arg = 16'($urandom);
        endcase
        clear_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, FrameLen - 1)) : -1;
        add_frame(cmd, arg, -1, pick >= 70, clear_at);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) begin
          push_beat(($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_RX_BYTE, 8'($urandom));
        end
      end else begin
        push_beat(OP_CLEAR, 8'($urandom));
      end
    end
    total_beats = byte_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (beats_sent != total_beats) @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && status_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin : byte_driver
    bit       present;
    in_beat_t next_beat;
    if (rst) begin
      byte_valid <= 1'b0;
      byte_beat  <= '0;
    end else begin
      if (byte_valid && !byte_stall) begin
        status_due.push_back(frame_status_next(byte_beat));
        beats_sent++;
      end
      if (!byte_valid || !byte_stall) begin
        present   = 1'b0;
        next_beat = '0;
        if (beats_sent == DrainPoint && !drain_done && status_due.size() == 0) begin
          drain_done = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_items.size() != 0 && (drain_done || beats_sent != DrainPoint)) begin
          present   = 1'b1;
          next_beat = byte_items.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
          end
        end
        byte_valid <= present;
        if (present) byte_beat <= next_beat;
      end
    end
  end

  always @(posedge clk) begin : status_stall_pattern
    if (rst) begin
      status_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = stall_mode_e'($urandom_range(0, 2));
        stall_phase_left = $urandom_range(20, 120);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        STALL_NONE:  status_stall <= 1'b0;
        STALL_LIGHT: status_stall <= ($urandom_range(0, 3) == 0);
        default:     status_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : status_monitor
    out_beat_t want;
    if (!rst && status_valid && !status_stall) begin
      if (status_due.size() == 0) begin
        $error("status beat arrived with no byte beat outstanding");
        error_count++;
      end else begin
        want = status_due.pop_front();
        check_field("frame_done", 32'(want.frame_done), 32'(status_beat.frame_done));
        check_field("frame_ok", 32'(want.frame_ok), 32'(status_beat.frame_ok));
        check_field("command_code", 32'(want.command_code), 32'(status_beat.command_code));
        check_field("argument_word", 32'(want.argument_word), 32'(status_beat.argument_word));
        check_field("volume_level", 32'(want.volume_level), 32'(status_beat.volume_level));
        check_field("file_total", 32'(want.file_total), 32'(status_beat.file_total));
        check_field("play_completed", 32'(want.play_completed),
                    32'(status_beat.play_completed));
        check_field("good_frames", want.good_frames, status_beat.good_frames);
      end
    end
  end

endmodule
